### design/mfbp_pkg.sv
// package for the msb-first bit packer
// operation codes, fixed widths and the result item type; no dependencies
`default_nettype none

package mfbp_pkg;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int HOLD_W   = 7;
    localparam int HCNT_W   = 3;
    localparam int MAXB_W   = 16;
    localparam int REM_W    = MAXB_W + HCNT_W;
    localparam int BCOUNT_W = 16;

    // capacity granted at start after reset
    localparam logic [MAXB_W-1:0] MAX_BYTES_RST = 16'd1024;

    // operation codes
    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_FINISH = 2'd1,
        OP_START  = 2'd2
    } t_op;

    // one result item
    typedef struct packed {
        logic                byte_valid;
        logic [BYTE_W-1:0]   data_byte;
        logic                last;
        logic                ok;
        logic [BCOUNT_W-1:0] bytes_written;
        logic [HCNT_W-1:0]   padding_bits;
    } t_result;

endpackage

`default_nettype wire

### design/msb_first_bit_packer.sv
// msb-first bit packer top level: input register, result bundle, output register
// depends on mfbp_pkg
`default_nettype none

//  channel   signals                                   direction
//  in        i_in_valid / o_in_ready, op, value, count input item
//  out       o_out_valid / i_out_ready, six fields     result item
//  cfg       i_cfg_wr_en, i_cfg_wr_data                max_bytes write
//
// an item passes input register -> bundle register -> output register to the port.
// an item that forms k bytes gives k+1 results (1 to 5 at FIELD_WIDTH 32), one per
// cycle from the output register while the out side does not stall; a status-only
// item gives only its status result. the bundle loads the next item as its status
// result moves out.
// reset is synchronous, active low, and disarms the packer; max_bytes returns to 1024.
// a stall on the out side holds every full stage; ready is combinational from i_out_ready.

module msb_first_bit_packer
    import mfbp_pkg::*;
#(
    parameter int FIELD_WIDTH = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration
    input  wire                              i_cfg_wr_en,
    input  wire  [MAXB_W-1:0]                i_cfg_wr_data,
    // input channel
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [1:0]                       i_operation,
    input  wire  [FIELD_WIDTH-1:0]           i_bit_value,
    input  wire  [$clog2(FIELD_WIDTH+1)-1:0] i_bit_count,
    // output channel
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_byte_valid,
    output logic [BYTE_W-1:0]                o_data_byte,
    output logic                             o_last,
    output logic                             o_ok,
    output logic [BCOUNT_W-1:0]              o_bytes_written,
    output logic [HCNT_W-1:0]                o_padding_bits
);

    localparam int CNT_W = $clog2(FIELD_WIDTH + 1);
    localparam int ACC_W = FIELD_WIDTH + HOLD_W;
    localparam int MAXB  = ACC_W / BYTE_W;
    localparam int LW    = BYTE_W * (MAXB + 1);
    localparam int SH_W  = $clog2(LW + 1);
    localparam int TOT_W = $clog2(ACC_W + 1);
    localparam int NB_W  = $clog2(MAXB + 1);

    // configuration register
    logic [MAXB_W-1:0] r_max_bytes;

    // packer state
    logic [HOLD_W-1:0]   r_hold_bits,      n_hold_bits;
    logic [HCNT_W-1:0]   r_hold_count,     n_hold_count;
    logic [REM_W-1:0]    r_bits_remaining, n_bits_remaining;
    logic [BCOUNT_W-1:0] r_bytes_emitted,  n_bytes_emitted;
    logic                r_armed,          n_armed;

    // input register
    logic             r_in_valid;
    t_op              r_in_op;
    logic [FIELD_WIDTH-1:0] r_in_value;
    logic [CNT_W-1:0] r_in_count;

    // bundle register: bytes of one item, then its status
    logic                r_bun_valid;
    logic [BYTE_W-1:0]   r_bun_bytes [MAXB];
    logic [NB_W-1:0]     r_bun_nbytes;
    logic                r_bun_ok;
    logic [BCOUNT_W-1:0] r_bun_written;
    logic [HCNT_W-1:0]   r_bun_pad;

    logic [BYTE_W-1:0]   n_bun_bytes [MAXB];
    logic [NB_W-1:0]     n_bun_nbytes;
    logic                n_bun_ok;
    logic [BCOUNT_W-1:0] n_bun_written;
    logic [HCNT_W-1:0]   n_bun_pad;

    // output register
    logic    r_out_valid;
    t_result r_out;
    t_result bun_front;

    // handshake control
    logic out_free, bun_pop, bun_done, bun_load, in_free;

    // packing datapath
    logic [FIELD_WIDTH-1:0] val_masked;
    logic [ACC_W-1:0]       acc;
    logic [TOT_W-1:0]       total;
    logic [LW-1:0]          aligned;
    logic                   put_ok;
    logic [HCNT_W-1:0]      fin_pad;

    assign out_free = !r_out_valid || i_out_ready;
    assign bun_pop  = r_bun_valid && out_free;
    assign bun_done = bun_pop && (r_bun_nbytes == '0);
    assign bun_load = r_in_valid && (!r_bun_valid || bun_done);
    assign in_free  = !r_in_valid || bun_load;
    assign o_in_ready = in_free;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RST;
        end else if (i_cfg_wr_en) begin
            r_max_bytes <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in_op    <= t_op'(i_operation);
            r_in_value <= i_bit_value;
            r_in_count <= i_bit_count;
        end
    end

    // merge pending bits with the new field and left-align the whole run
    always_comb begin
        val_masked = r_in_value & ~({FIELD_WIDTH{1'b1}} << r_in_count);
        acc        = (ACC_W'(r_hold_bits) << r_in_count) | ACC_W'(val_masked);
        total      = TOT_W'(r_hold_count) + TOT_W'(r_in_count);
        aligned    = LW'(acc) << (SH_W'(LW) - SH_W'(total));
        put_ok     = r_armed
                     && ({1'b0, r_in_count} <= (CNT_W+1)'(FIELD_WIDTH))
                     && (REM_W'(r_in_count) <= r_bits_remaining);
        fin_pad    = HCNT_W'(0) - r_hold_count;
    end

    // next state and bundle contents for the item in the input register
    always_comb begin
        n_hold_bits      = r_hold_bits;
        n_hold_count     = r_hold_count;
        n_bits_remaining = r_bits_remaining;
        n_bytes_emitted  = r_bytes_emitted;
        n_armed          = r_armed;
        n_bun_nbytes     = '0;
        n_bun_ok         = 1'b0;
        n_bun_written    = '0;
        n_bun_pad        = '0;
        for (int j = 0; j < MAXB; j++) begin
            n_bun_bytes[j] = aligned[LW-1-BYTE_W*j -: BYTE_W];
        end
        case (r_in_op)
            OP_PUT: begin
                if (put_ok) begin
                    n_bun_ok         = 1'b1;
                    n_bun_nbytes     = NB_W'(total >> 3);
                    n_hold_count     = total[HCNT_W-1:0];
                    n_hold_bits      = HOLD_W'(acc & ~({ACC_W{1'b1}} << total[HCNT_W-1:0]));
                    n_bits_remaining = r_bits_remaining - REM_W'(r_in_count);
                    n_bytes_emitted  = r_bytes_emitted + BCOUNT_W'(total >> 3);
                end
            end
            OP_FINISH: begin
                if (r_armed) begin
                    n_bun_ok = 1'b1;
                    if (r_hold_count != '0) begin
                        n_bun_nbytes   = NB_W'(1);
                        n_bun_bytes[0] = BYTE_W'(r_hold_bits) << fin_pad;
                        n_bun_pad      = fin_pad;
                        n_bun_written  = r_bytes_emitted + BCOUNT_W'(1);
                    end else begin
                        n_bun_written  = r_bytes_emitted;
                    end
                    n_hold_bits      = '0;
                    n_hold_count     = '0;
                    n_bits_remaining = '0;
                    n_bytes_emitted  = '0;
                    n_armed          = 1'b0;
                end
            end
            OP_START: begin
                n_hold_bits      = '0;
                n_hold_count     = '0;
                n_bytes_emitted  = '0;
                n_armed          = (r_max_bytes != '0);
                n_bun_ok         = (r_max_bytes != '0);
                n_bits_remaining = (r_max_bytes != '0) ? {r_max_bytes, 3'b000} : '0;
            end
            default: begin
                // reserved code: refused, state unchanged
                n_bun_ok = 1'b0;
            end
        endcase
    end

    // packer state update as an item moves into the bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_bits      <= '0;
            r_hold_count     <= '0;
            r_bits_remaining <= '0;
            r_bytes_emitted  <= '0;
            r_armed          <= 1'b0;
        end else if (bun_load) begin
            r_hold_bits      <= n_hold_bits;
            r_hold_count     <= n_hold_count;
            r_bits_remaining <= n_bits_remaining;
            r_bytes_emitted  <= n_bytes_emitted;
            r_armed          <= n_armed;
        end
    end

    // bundle valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bun_valid <= 1'b0;
        end else if (bun_load) begin
            r_bun_valid <= 1'b1;
        end else if (bun_done) begin
            r_bun_valid <= 1'b0;
        end
    end

    // bundle payload: load, or shift the byte line by one per result sent
    always_ff @(posedge i_clk) begin
        if (bun_load) begin
            for (int j = 0; j < MAXB; j++) begin
                r_bun_bytes[j] <= n_bun_bytes[j];
            end
            r_bun_nbytes  <= n_bun_nbytes;
            r_bun_ok      <= n_bun_ok;
            r_bun_written <= n_bun_written;
            r_bun_pad     <= n_bun_pad;
        end else if (bun_pop && (r_bun_nbytes != '0)) begin
            for (int j = 0; j < MAXB - 1; j++) begin
                r_bun_bytes[j] <= r_bun_bytes[j+1];
            end
            r_bun_nbytes <= r_bun_nbytes - NB_W'(1);
        end
    end

    // front result of the bundle: next byte, or the closing status
    always_comb begin
        if (r_bun_nbytes != '0) begin
            bun_front.byte_valid    = 1'b1;
            bun_front.data_byte     = r_bun_bytes[0];
            bun_front.last          = 1'b0;
            bun_front.ok            = 1'b1;
            bun_front.bytes_written = '0;
            bun_front.padding_bits  = '0;
        end else begin
            bun_front.byte_valid    = 1'b0;
            bun_front.data_byte     = '0;
            bun_front.last          = 1'b1;
            bun_front.ok            = r_bun_ok;
            bun_front.bytes_written = r_bun_written;
            bun_front.padding_bits  = r_bun_pad;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_bun_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= bun_front;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_valid    = r_out.byte_valid;
    assign o_data_byte     = r_out.data_byte;
    assign o_last          = r_out.last;
    assign o_ok            = r_out.ok;
    assign o_bytes_written = r_out.bytes_written;
    assign o_padding_bits  = r_out.padding_bits;

`ifndef SYNTHESIS
    // pending bits above the pending count stay clear
    a_hold_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ACC_W'(r_hold_bits) >> r_hold_count) == '0)
        else $error("pending bits above hold count");

    // an unarmed packer keeps no pending bits and no byte count
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_hold_count == '0) && (r_bytes_emitted == '0))
        else $error("state left over while unarmed");

    // a result is either a byte or a closing status
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.byte_valid != r_out.last))
        else $error("result is neither byte nor status");

    // a bundle never holds more bytes than one item can form
    a_bundle_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bun_valid |-> (32'(r_bun_nbytes) <= MAXB))
        else $error("bundle byte count out of range");

    // a byte result carries success and no finish report
    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.byte_valid) |->
            (r_out.ok && (r_out.bytes_written == '0) && (r_out.padding_bits == '0)))
        else $error("byte result carries status fields");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_msb_first_bit_packer.sv
`timescale 1ns / 100ps
// self-checking testbench for msb_first_bit_packer: directed and random put/finish/start
// items with random gaps on both sides; depends on mfbp_pkg and the packer rtl

module tb_msb_first_bit_packer
    import mfbp_pkg::*;
();

    localparam int          FIELD_W        = 32;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          DRAIN_CYCLES   = 10;

    // bit-accurate model of the packer plus the queue of results still owed
    class packer_scoreboard;
        logic [15:0] capacity;
        logic [6:0]  pend_bits;
        logic [2:0]  pend_cnt;
        logic [18:0] room_bits;
        logic [15:0] byte_total;
        bit          is_armed;
        t_result     owed_results[$];
        int          errors;
        int          checked;
        int          refused;

        function new();
            capacity = MAX_BYTES_RST;
            errors   = 0;
            checked  = 0;
            refused  = 0;
            clear_packing();
        endfunction

        function void clear_packing();
            pend_bits  = '0;
            pend_cnt   = '0;
            room_bits  = '0;
            byte_total = '0;
            is_armed   = 1'b0;
        endfunction

        function void owe(bit bv, logic [7:0] data, bit fin, bit good,
                          logic [15:0] written, logic [2:0] pad);
            t_result r;
            r.byte_valid    = bv;
            r.data_byte     = data;
            r.last          = fin;
            r.ok            = good;
            r.bytes_written = written;
            r.padding_bits  = pad;
            if (fin && !good)
                refused++;
            owed_results.push_back(r);
        endfunction

        // work out every result that one accepted item causes
        function void take_item(logic [1:0] op, logic [31:0] value, logic [5:0] count);
            logic [7:0] acc;
            int         n;
            logic [2:0] pad;
            if (op == OP_START) begin
                clear_packing();
                if (capacity != 0) begin
                    is_armed  = 1'b1;
                    room_bits = {capacity, 3'b000};
                end
                owe(0, 8'h00, 1, is_armed, 16'd0, 3'd0);
            end else if (op == OP_PUT) begin
                if (!is_armed || count > FIELD_W || count > room_bits) begin
                    owe(0, 8'h00, 1, 0, 16'd0, 3'd0);
                end else begin
                    acc = {1'b0, pend_bits};
                    n   = pend_cnt;
                    // shift in from the top bit of the field down
                    for (int i = int'(count) - 1; i >= 0; i--) begin
                        acc = {acc[6:0], value[i]};
                        n++;
                        if (n == 8) begin
                            owe(1, acc, 0, 1, 16'd0, 3'd0);
                            byte_total++;
                            acc = '0;
                            n   = 0;
                        end
                    end
                    pend_bits = acc[6:0];
                    pend_cnt  = n[2:0];
                    room_bits = room_bits - count;
                    owe(0, 8'h00, 1, 1, 16'd0, 3'd0);
                end
            end else if (op == OP_FINISH) begin
                if (!is_armed) begin
                    owe(0, 8'h00, 1, 0, 16'd0, 3'd0);
                end else begin
                    pad = 3'd0;
                    if (pend_cnt != 0) begin
                        pad = 3'(8 - pend_cnt);
                        acc = {1'b0, pend_bits} << pad;
                        owe(1, acc, 0, 1, 16'd0, 3'd0);
                        byte_total++;
                    end
                    owe(0, 8'h00, 1, 1, byte_total, pad);
                    clear_packing();
                end
            end else begin
                owe(0, 8'h00, 1, 0, 16'd0, 3'd0);
            end
        endfunction

        // compare one accepted result with the oldest one owed
        function void check_result(t_result got);
            t_result want;
            checked++;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result valid=%0b byte=%02h last=%0b ok=%0b wr=%0d pad=%0d",
                         $time, got.byte_valid, got.data_byte, got.last, got.ok,
                         got.bytes_written, got.padding_bits);
                return;
            end
            want = owed_results.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch expected valid=%0b byte=%02h last=%0b ok=%0b wr=%0d pad=%0d",
                         $time, want.byte_valid, want.data_byte, want.last, want.ok,
                         want.bytes_written, want.padding_bits);
                $display("%0t:          actual   valid=%0b byte=%02h last=%0b ok=%0b wr=%0d pad=%0d",
                         $time, got.byte_valid, got.data_byte, got.last, got.ok,
                         got.bytes_written, got.padding_bits);
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_wr_en    = 1'b0;
    logic [MAXB_W-1:0]  i_cfg_wr_data  = '0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_operation    = OP_PUT;
    logic [FIELD_W-1:0] i_bit_value    = '0;
    logic [5:0]         i_bit_count    = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic               o_byte_valid;
    logic [BYTE_W-1:0]  o_data_byte;
    logic               o_last;
    logic               o_ok;
    logic [BCOUNT_W-1:0] o_bytes_written;
    logic [HCNT_W-1:0]  o_padding_bits;

    packer_scoreboard sb = new();
    bit               calm        = 1'b0;
    int               stall_left  = 0;
    int               idle_cycles = 0;
    int               items_sent  = 0;
    int               cap_writes  = 0;

    msb_first_bit_packer #(
        .FIELD_WIDTH (FIELD_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_bit_value     (i_bit_value),
        .i_bit_count     (i_bit_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_byte_valid    (o_byte_valid),
        .o_data_byte     (o_data_byte),
        .o_last          (o_last),
        .o_ok            (o_ok),
        .o_bytes_written (o_bytes_written),
        .o_padding_bits  (o_padding_bits)
    );

    always #2 i_clk = ~i_clk;

    // result side back-pressure: mostly short stalls, now and then a long one
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready = 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 30) begin
            stall_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 29)
                                                      : $urandom_range(0, 2);
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // check every accepted result
    always @(posedge i_clk) begin
        t_result seen;
        seen.byte_valid    = o_byte_valid;
        seen.data_byte     = o_data_byte;
        seen.last          = o_last;
        seen.ok            = o_ok;
        seen.bytes_written = o_bytes_written;
        seen.padding_bits  = o_padding_bits;
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(seen);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout at %0t with %0d results outstanding", $time, sb.pending());
            $display("tb_msb_first_bit_packer: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [5:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 6'd32;
        if (r < 25)
            return 6'($urandom_range(1, 8));
        if (r < 29)
            return 6'($urandom_range(33, 63));
        return 6'($urandom_range(0, 32));
    endfunction

    // offer one item and wait until it is taken
    task automatic send_item(input logic [1:0] op, input logic [31:0] value,
                             input logic [5:0] count);
        int gap;
        gap = calm ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_operation = op;
        i_bit_value = value;
        i_bit_count = count;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_item(op, value, count);
        items_sent++;
    endtask

    // capacity changes only once the packer has drained
    task automatic write_capacity(input logic [15:0] cap);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = cap;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sb.capacity   = cap;
        cap_writes++;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(OP_UNUSED, $urandom, 6'($urandom_range(0, 63)));
            1: send_item(OP_PUT, $urandom, 6'($urandom_range(33, 63)));
            2: send_item(OP_FINISH, $urandom, 6'($urandom_range(0, 63)));
            default: send_item(OP_PUT, $urandom, pick_count());
        endcase
    endtask

    // mostly start / puts / finish frames with random content, some broken or noise
    task automatic random_phase(input logic [15:0] cap, input int n_items);
        int first;
        int pick;
        int n_puts;
        write_capacity(cap);
        first = items_sent;
        while (items_sent - first < n_items) begin
            calm = ($urandom_range(0, 99) < 15);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_noise();
            end else begin
                if (pick >= 12)
                    send_item(OP_START, $urandom, 6'($urandom_range(0, 63)));
                n_puts = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12)
                                                     : $urandom_range(0, 6);
                repeat (n_puts) send_item(OP_PUT, $urandom, pick_count());
                if (pick < 95)
                    send_item(OP_FINISH, $urandom, 6'($urandom_range(0, 63)));
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // unarmed requests, unused code, field extremes at the reset capacity
        send_item(OP_PUT, 32'h0000_001F, 6'd5);
        send_item(OP_FINISH, 32'h0, 6'd0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_START, 32'h0, 6'd0);
        send_item(OP_PUT, 32'hFFFF_FFFF, 6'd0);
        send_item(OP_PUT, 32'hFFFF_FFFF, 6'd32);
        send_item(OP_PUT, 32'h0000_0000, 6'd32);
        send_item(OP_PUT, 32'hFFFF_FFFF, 6'd33);
        send_item(OP_PUT, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_PUT, 32'h0000_0001, 6'd1);
        send_item(OP_PUT, 32'hFFFF_FF2A, 6'd7);
        // byte-aligned finish, then a finish that needs padding
        send_item(OP_FINISH, 32'h0, 6'd0);
        send_item(OP_START, 32'h0, 6'd0);
        send_item(OP_PUT, 32'hA5A5_A5A5, 6'd3);
        send_item(OP_FINISH, 32'h0, 6'd0);

        // one-byte capacity: refusals once the byte is nearly full
        write_capacity(16'd1);
        send_item(OP_START, 32'h0, 6'd0);
        send_item(OP_PUT, 32'h0000_0016, 6'd5);
        send_item(OP_PUT, 32'h0000_000F, 6'd4);
        send_item(OP_PUT, 32'h0000_0005, 6'd3);
        send_item(OP_PUT, 32'h0000_0001, 6'd1);
        send_item(OP_FINISH, 32'h0, 6'd0);

        // zero capacity never arms
        write_capacity(16'd0);
        send_item(OP_START, 32'h0, 6'd0);
        send_item(OP_PUT, 32'h0000_0003, 6'd2);
        send_item(OP_FINISH, 32'h0, 6'd0);

        random_phase(16'd1024, 30);
        random_phase(16'd1, 30);
        random_phase(16'd3, 30);
        random_phase(16'($urandom_range(2, 16)), 30);
        random_phase(16'hFFFF, 30);
        random_phase(16'd2, 30);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d items (%0d refused) and %0d results over %0d capacity writes",
                 items_sent, sb.refused, sb.checked, cap_writes);
        if (sb.errors == 0) begin
            $display("tb_msb_first_bit_packer: PASS");
        end else begin
            $display("%0d errors", sb.errors);
            $display("tb_msb_first_bit_packer: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
design/mfbp_pkg.sv
design/msb_first_bit_packer.sv
tb/sv/tb_msb_first_bit_packer.sv
